// ===== src/sfu_pkg.sv =====
// ----------------------------------------------------------------------------
// sfu_pkg
// Shared types and codes for the latent factor update engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sfu_pkg;

    // Command codes of an input beat
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    // Configuration register indexes
    localparam logic REG_STEP_SIZE  = 1'b0;
    localparam logic REG_REG_LAMBDA = 1'b1;

    localparam logic [23:0] STEP_SIZE_RST  = 24'd16777;
    localparam logic [23:0] REG_LAMBDA_RST = 24'd16777;

    localparam logic signed [23:0] LAT_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] LAT_MIN = -24'sh800000;

    typedef struct packed {
        logic [1:0]         command;
        logic               side;
        logic [9:0]         movie_index;
        logic [11:0]        user_index;
        logic [4:0]         element;
        logic [7:0]         rating;
        logic signed [23:0] element_value;
    } sfu_item_t;

    typedef struct packed {
        logic signed [23:0] read_value;
        logic signed [31:0] error_value;
        logic               saturated;
    } sfu_result_t;

    // Stage strobes for the element update lanes
    typedef struct packed {
        logic mul_en;
        logic grad_en;
        logic step_en;
    } sfu_lane_ctl_t;

endpackage

`default_nettype wire

// ===== src/sfu_lane.sv =====
// ----------------------------------------------------------------------------
// sfu_lane
// One latent element update: new = self + step*(err*other - lambda*self),
// with half-up rounding at each stage and saturation to signed Q4.20.
// ----------------------------------------------------------------------------
`default_nettype none

module sfu_lane
    import sfu_pkg::*;
(
    input  wire logic               aclk,
    input  wire sfu_lane_ctl_t      ctl,
    input  wire logic signed [23:0] self_val,
    input  wire logic signed [23:0] other_val,
    input  wire logic signed [31:0] err_val,
    input  wire logic [23:0]        step_size,
    input  wire logic [23:0]        reg_lambda,
    output logic signed [23:0]      new_val,
    output logic                    sat
);

    logic signed [23:0] self_reg;
    logic signed [55:0] p_eu_reg;
    logic signed [48:0] p_lm_reg;
    logic signed [37:0] g20_reg;
    logic signed [44:0] ph_reg;
    logic [41:0]        pl_reg;

    logic signed [61:0] grad;
    logic signed [61:0] grad_rnd;
    logic signed [62:0] prod;
    logic signed [62:0] prod_rnd;
    logic signed [39:0] sum;

    // Gradient and step products
    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            self_reg <= self_val;
            p_eu_reg <= err_val * other_val;
            p_lm_reg <= $signed({1'b0, reg_lambda}) * self_val;
        end
        if (ctl.grad_en) begin
            g20_reg <= grad_rnd[61:24];
        end
        if (ctl.step_en) begin
            ph_reg <= $signed({1'b0, step_size}) * $signed(g20_reg[37:18]);
            pl_reg <= step_size * g20_reg[17:0];
        end
    end

    // Gradient in Q.44, rounded to Q.20
    always_comb begin
        grad     = $signed({{2{p_eu_reg[55]}}, p_eu_reg, 4'b0000})
                 - $signed({{13{p_lm_reg[48]}}, p_lm_reg});
        grad_rnd = grad + 62'sd8388608;
    end

    // Step product rebuilt from its halves, rounded, added and clamped
    always_comb begin
        prod     = $signed({ph_reg, 18'b0}) + $signed({21'b0, pl_reg});
        prod_rnd = prod + 63'sd8388608;
        sum      = $signed({{16{self_reg[23]}}, self_reg})
                 + $signed({prod_rnd[62], prod_rnd[62:24]});
        sat      = 1'b0;
        new_val  = sum[23:0];
        if (sum > $signed({{16{LAT_MAX[23]}}, LAT_MAX})) begin
            new_val = LAT_MAX;
            sat     = 1'b1;
        end else if (sum < $signed({{16{LAT_MIN[23]}}, LAT_MIN})) begin
            new_val = LAT_MIN;
            sat     = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== src/sgd_factor_update.sv =====
// ----------------------------------------------------------------------------
// sgd_factor_update
// Latent factor store with element read/write and one SGD rating update step.
// ----------------------------------------------------------------------------
//  channel | ports                          | carries
//  --------+--------------------------------+------------------------------
//  input   | s_valid, s_ready, s_item       | command beat (sfu_item_t)
//  result  | m_valid, m_ready, m_result     | one result beat per command
//  config  | psel, penable, pwrite, paddr.. | step_size @0x0, reg_lambda @0x4
//
// Write and unused commands pass through EXEC and DONE; a read adds RWAIT, and
// an update runs DRD, DMUL and DACC per element, ERR, then URD, UMUL, UGRAD,
// USTEP and UWB per element, then DONE: each element costs one read of the
// single memory port per pass, and the update lanes run one element at a time.
// The next beat can be taken as soon as the result enters the output register,
// while that result waits there. The memories are not cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sgd_factor_update
    import sfu_pkg::*;
#(
    parameter int LATENT_LEN     = 20,
    parameter int MOVIE_CAPACITY = 1024,
    parameter int USER_CAPACITY  = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire sfu_item_t   s_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output sfu_result_t      m_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int MDEPTH  = MOVIE_CAPACITY * LATENT_LEN;
    localparam int UDEPTH  = USER_CAPACITY * LATENT_LEN;
    localparam int MADDR_W = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
    localparam int UADDR_W = (UDEPTH > 1) ? $clog2(UDEPTH) : 1;
    localparam int IDX_W   = (LATENT_LEN > 1) ? $clog2(LATENT_LEN) : 1;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_EXEC  = 13'b0000000000010,
        ST_RWAIT = 13'b0000000000100,
        ST_DRD   = 13'b0000000001000,
        ST_DMUL  = 13'b0000000010000,
        ST_DACC  = 13'b0000000100000,
        ST_ERR   = 13'b0000001000000,
        ST_URD   = 13'b0000010000000,
        ST_UMUL  = 13'b0000100000000,
        ST_UGRAD = 13'b0001000000000,
        ST_USTEP = 13'b0010000000000,
        ST_UWB   = 13'b0100000000000,
        ST_DONE  = 13'b1000000000000
    } state_t;

    state_t              state_reg, state_next;
    sfu_item_t           item_reg, item_next;
    sfu_result_t         res_reg, res_next;
    sfu_result_t         out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic signed [55:0]  acc_reg, acc_next;
    logic signed [47:0]  prod_reg, prod_next;
    logic signed [31:0]  err_reg, err_next;
    logic [23:0]         step_size_reg, reg_lambda_reg;

    logic signed [23:0]  movie_mem [MDEPTH];
    logic signed [23:0]  user_mem  [UDEPTH];
    logic signed [23:0]  mq, uq;
    logic [MADDR_W-1:0]  madr;
    logic [UADDR_W-1:0]  uadr;
    logic                mwe, uwe;
    logic signed [23:0]  mwd, uwd;

    logic                m_ok, u_ok, el_ok, last;
    logic [31:0]         offs;
    logic signed [56:0]  err_full;
    logic signed [36:0]  err37;

    sfu_lane_ctl_t       lane_ctl;
    logic signed [23:0]  m_new, u_new;
    logic                m_sat, u_sat;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg  <= STEP_SIZE_RST;
            reg_lambda_reg <= REG_LAMBDA_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_REG_LAMBDA) begin
                reg_lambda_reg <= pwdata[23:0];
            end else begin
                step_size_reg <= pwdata[23:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REG_LAMBDA) ? {8'b0, reg_lambda_reg}
                                                 : {8'b0, step_size_reg};

    // Range checks and addresses
    assign m_ok  = {22'b0, item_reg.movie_index} < 32'(MOVIE_CAPACITY);
    assign u_ok  = {20'b0, item_reg.user_index} < 32'(USER_CAPACITY);
    assign el_ok = {27'b0, item_reg.element} < 32'(LATENT_LEN);
    assign last  = idx_reg == IDX_W'(LATENT_LEN - 1);
    assign offs  = (state_reg == ST_EXEC) ? {27'b0, item_reg.element}
                                          : 32'(idx_reg);
    assign madr  = MADDR_W'(32'(item_reg.movie_index) * LATENT_LEN + offs);
    assign uadr  = UADDR_W'(32'(item_reg.user_index) * LATENT_LEN + offs);

    // Latent stores
    always_ff @(posedge aclk) begin
        if (mwe) begin
            movie_mem[madr] <= mwd;
        end
        mq <= movie_mem[madr];
    end

    always_ff @(posedge aclk) begin
        if (uwe) begin
            user_mem[uadr] <= uwd;
        end
        uq <= user_mem[uadr];
    end

    // Error from the dot product: round half up to Q.20
    always_comb begin
        err_full = $signed({9'b0, item_reg.rating, 40'b0})
                 - $signed({acc_reg[55], acc_reg});
        err_full = err_full + 57'sd524288;
        err37    = err_full[56:20];
    end

    assign lane_ctl.mul_en  = (state_reg == ST_UMUL);
    assign lane_ctl.grad_en = (state_reg == ST_UGRAD);
    assign lane_ctl.step_en = (state_reg == ST_USTEP);

    sfu_lane u_mlane (
        .aclk       (aclk),
        .ctl        (lane_ctl),
        .self_val   (mq),
        .other_val  (uq),
        .err_val    (err_reg),
        .step_size  (step_size_reg),
        .reg_lambda (reg_lambda_reg),
        .new_val    (m_new),
        .sat        (m_sat)
    );

    sfu_lane u_ulane (
        .aclk       (aclk),
        .ctl        (lane_ctl),
        .self_val   (uq),
        .other_val  (mq),
        .err_val    (err_reg),
        .step_size  (step_size_reg),
        .reg_lambda (reg_lambda_reg),
        .new_val    (u_new),
        .sat        (u_sat)
    );

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        err_next       = err_reg;
        mwe            = 1'b0;
        uwe            = 1'b0;
        mwd            = item_reg.element_value;
        uwd            = item_reg.element_value;

        // drop the result beat once taken
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_next   = '0;
                state_next = ST_DONE;
                case (item_reg.command)
                    CMD_WRITE: begin
                        if (el_ok) begin
                            mwe = !item_reg.side && m_ok;
                            uwe = item_reg.side && u_ok;
                        end
                    end
                    CMD_READ: begin
                        if (el_ok && (item_reg.side ? u_ok : m_ok)) begin
                            state_next = ST_RWAIT;
                        end
                    end
                    CMD_UPDATE: begin
                        if (m_ok && u_ok) begin
                            idx_next   = '0;
                            acc_next   = '0;
                            state_next = ST_DRD;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RWAIT: begin
                res_next.read_value = item_reg.side ? uq : mq;
                state_next          = ST_DONE;
            end
            ST_DRD: begin
                state_next = ST_DMUL;
            end
            ST_DMUL: begin
                prod_next  = mq * uq;
                state_next = ST_DACC;
            end
            ST_DACC: begin
                acc_next = acc_reg + $signed({{8{prod_reg[47]}}, prod_reg});
                if (last) begin
                    idx_next   = '0;
                    state_next = ST_ERR;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_DRD;
                end
            end
            ST_ERR: begin
                // saturate the error to 32 bits
                if (err37 > 37'sh7FFFFFFF) begin
                    err_next           = 32'sh7FFFFFFF;
                    res_next.saturated = 1'b1;
                end else if (err37 < -37'sh80000000) begin
                    err_next           = -32'sh80000000;
                    res_next.saturated = 1'b1;
                end else begin
                    err_next = err37[31:0];
                end
                state_next = ST_URD;
            end
            ST_URD: begin
                state_next = ST_UMUL;
            end
            ST_UMUL: begin
                state_next = ST_UGRAD;
            end
            ST_UGRAD: begin
                state_next = ST_USTEP;
            end
            ST_USTEP: begin
                state_next = ST_UWB;
            end
            ST_UWB: begin
                mwe                = 1'b1;
                uwe                = 1'b1;
                mwd                = m_new;
                uwd                = u_new;
                res_next.saturated = res_reg.saturated | m_sat | u_sat;
                if (last) begin
                    res_next.error_value = err_reg;
                    state_next           = ST_DONE;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_URD;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!out_valid_reg || m_ready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        idx_reg  <= idx_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        err_reg  <= err_next;
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

`default_nettype wire

// ===== src/sfu_checker.sv =====
// ----------------------------------------------------------------------------
// sfu_checker
// Port-level checks for the latent factor update engine, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module sfu_checker
    import sfu_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire sfu_item_t   s_item,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire sfu_result_t m_result,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    // Result beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result beat changed while stalled");

    // No result right after reset
    a_rst_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One beat at a time: busy after an accepted beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // A written register reads back its value
    a_cfg_rb: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready ##1 !(psel && penable && pwrite)
        && (paddr[2] == $past(paddr[2]))
        |-> prdata[23:0] == $past(pwdata[23:0]))
        else $error("configuration readback mismatch");

endmodule

bind sgd_factor_update sfu_checker u_sfu_checker (.*);

`default_nettype wire
